[hdl/ufis_pkg.sv]
// Package with status codes, microcode fields and the sequencer program.
`default_nettype none
package ufis_pkg;

	localparam int CFG_W = 16;
	localparam int SRC_W = 16;
	localparam int IDX_W = 16;
	localparam int N_W = 7;
	localparam int GRP_W = 5;
	localparam int PC_W = 4;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_FEW = 2'd1;
	localparam status_t ST_FPS0 = 2'd2;

	localparam logic [1:0] REG_TARGET_FPS = 2'd0;
	localparam logic [1:0] REG_MAX_FRAMES = 2'd1;
	localparam logic [1:0] REG_GROUP_SIZE = 2'd2;

	localparam logic [1:0] DL_NONE = 2'd0;
	localparam logic [1:0] DL_PROD = 2'd1;
	localparam logic [1:0] DL_NG = 2'd2;
	localparam logic [1:0] DL_SPAN = 2'd3;

	localparam logic [2:0] C_NEVER = 3'd0;
	localparam logic [2:0] C_ALWAYS = 3'd1;
	localparam logic [2:0] C_NO_REQ = 3'd2;
	localparam logic [2:0] C_ERR = 3'd3;
	localparam logic [2:0] C_BUSY = 3'd4;
	localparam logic [2:0] C_NSMALL = 3'd5;
	localparam logic [2:0] C_MORE = 3'd6;

	localparam logic [PC_W-1:0] S_WAIT = 4'd0;
	localparam logic [PC_W-1:0] S_CHECK = 4'd1;
	localparam logic [PC_W-1:0] S_DIV1 = 4'd2;
	localparam logic [PC_W-1:0] S_CLAMP = 4'd3;
	localparam logic [PC_W-1:0] S_DIV2 = 4'd4;
	localparam logic [PC_W-1:0] S_ROUND = 4'd5;
	localparam logic [PC_W-1:0] S_DIV3 = 4'd6;
	localparam logic [PC_W-1:0] S_STEP = 4'd7;
	localparam logic [PC_W-1:0] S_EMIT = 4'd8;
	localparam logic [PC_W-1:0] S_END = 4'd9;

	typedef struct packed {
		logic in_rdy;
		logic chk;
		logic [1:0] div_ld;
		logic div_run;
		logic clamp;
		logic round;
		logic step_ld;
		logic emit;
		logic [2:0] cond;
		logic [PC_W-1:0] tgt;
	} uword_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '0;
		case (pc)
			S_WAIT: begin
				w.in_rdy = 1'b1;
				w.cond = C_NO_REQ;
				w.tgt = S_WAIT;
			end
			S_CHECK: begin
				w.chk = 1'b1;
				w.div_ld = DL_PROD;
				w.cond = C_ERR;
				w.tgt = S_EMIT;
			end
			S_DIV1: begin
				w.div_run = 1'b1;
				w.cond = C_BUSY;
				w.tgt = S_DIV1;
			end
			S_CLAMP: begin
				w.clamp = 1'b1;
				w.div_ld = DL_NG;
			end
			S_DIV2: begin
				w.div_run = 1'b1;
				w.cond = C_BUSY;
				w.tgt = S_DIV2;
			end
			S_ROUND: begin
				w.round = 1'b1;
				w.div_ld = DL_SPAN;
				w.cond = C_NSMALL;
				w.tgt = S_EMIT;
			end
			S_DIV3: begin
				w.div_run = 1'b1;
				w.cond = C_BUSY;
				w.tgt = S_DIV3;
			end
			S_STEP: begin
				w.step_ld = 1'b1;
			end
			S_EMIT: begin
				w.emit = 1'b1;
				w.cond = C_MORE;
				w.tgt = S_EMIT;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.tgt = S_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[hdl/ufis_if.sv]
// Request and result channel interfaces of the frame index sampler.
`default_nettype none
interface ufis_req_if #(
	parameter int FRAME_COUNT_BITS = 16
);
	import ufis_pkg::*;
	logic valid;
	logic ready;
	logic [FRAME_COUNT_BITS-1:0] total_frames;
	logic [SRC_W-1:0] source_fps;
	modport source (output valid, output total_frames, output source_fps, input ready);
	modport sink (input valid, input total_frames, input source_fps, output ready);
endinterface

interface ufis_res_if;
	import ufis_pkg::*;
	logic valid;
	logic ready;
	logic [IDX_W-1:0] frame_index;
	status_t status;
	logic last;
	modport source (output valid, output frame_index, output status, output last, input ready);
	modport sink (input valid, input frame_index, input status, input last, output ready);
endinterface
`default_nettype wire

[hdl/uniform_frame_index_sampler_core.sv]
// Uniform temporal frame sampler: picks evenly spaced frame indices per video request.
//
// A request on req carries the frame count and source frame rate of one video.
// The block answers on res with a burst of results, one per sampled frame, the
// final one flagged by last; an invalid request gives one result with a nonzero
// status and index 0. The target rate, frame limit and group size registers are
// written through cfg_wr_en, cfg_index and cfg_data; the user must write them
// only while no request is open, as the block itself does not enforce this.
// A microcoded sequencer drives one shared restoring divider, one bit per cycle:
// it finds the sample count, then the count rounded to the group, then the
// index step. Indices then leave at one per cycle while res is ready, by
// remainder stepping. A request with a single sample skips the index step,
// and an invalid request goes straight from the check to its result.
// One request is handled at a time; req.ready is high only
// between requests. A stalled res holds the current result and the sequencer.
// Reset returns the sequencer to waiting and the registers to 512, 64 and 2.
`default_nettype none
module uniform_frame_index_sampler_core #(
	parameter int MAX_SAMPLES = 64,
	parameter int FRAME_COUNT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [1:0] cfg_index,
	input wire logic [ufis_pkg::CFG_W-1:0] cfg_data,
	ufis_req_if.sink req,
	ufis_res_if.source res
);
	import ufis_pkg::*;

	localparam int FCB = FRAME_COUNT_BITS;
	localparam int W = FCB + SRC_W;
	localparam int CW = $clog2(W + 1);
	localparam logic [N_W-1:0] MAX_N = N_W'(MAX_SAMPLES);

	logic [SRC_W-1:0] tfps_q;
	logic [N_W-1:0] maxf_q;
	logic [GRP_W-1:0] grp_q;

	logic [PC_W-1:0] pc_q;
	uword_t uw;

	logic [FCB-1:0] total_q;
	logic [SRC_W-1:0] src_q;
	logic [W-1:0] dvd_q;
	logic [SRC_W-1:0] dsr_q;
	logic [SRC_W-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [N_W-1:0] n_q;
	logic [N_W-1:0] i_q;
	logic [FCB-1:0] acc_q;
	logic [N_W-1:0] accr_q;
	logic [FCB-1:0] q0_q;
	logic [N_W-1:0] r0_q;
	status_t st_q;

	logic [GRP_W-1:0] g_eff;
	status_t err_code;
	logic [SRC_W:0] rem_sh;
	logic qbit;
	logic [SRC_W:0] rem_nx;
	logic [N_W-1:0] n_clamp;
	logic [N_W-1:0] n_round;
	logic [N_W-1:0] n_down;
	logic [N_W-1:0] d_n;
	logic [N_W:0] acc_sum;
	logic is_last;
	logic req_fire;
	logic res_fire;
	logic cond_hit;
	logic [FCB+IDX_W-1:0] idx_ext;

	assign uw = ucode(pc_q);
	assign g_eff = (grp_q == '0) ? GRP_W'(1) : grp_q;
	assign req_fire = req.valid && req.ready;
	assign res_fire = res.valid && res.ready;
	assign d_n = n_q - N_W'(1);
	assign is_last = (i_q == d_n);

	always_comb begin
		if (total_q < FCB'(g_eff)) begin
			err_code = ST_FEW;
		end else if (src_q == '0) begin
			err_code = ST_FPS0;
		end else begin
			err_code = ST_OK;
		end
	end

	assign rem_sh = {rem_q, dvd_q[W-1]};
	assign qbit = (rem_sh >= {1'b0, dsr_q});
	assign rem_nx = qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

	always_comb begin
		n_clamp = maxf_q;
		if (total_q < FCB'(n_clamp)) begin
			n_clamp = total_q[N_W-1:0];
		end
		if (MAX_N < n_clamp) begin
			n_clamp = MAX_N;
		end
		if (dvd_q < W'(n_clamp)) begin
			n_clamp = dvd_q[N_W-1:0];
		end
	end

	always_comb begin
		n_down = n_q - rem_q[N_W-1:0];
		n_round = n_down;
		if (n_round < N_W'(g_eff)) begin
			n_round = N_W'(g_eff);
		end
		if (n_round > MAX_N) begin
			n_round = MAX_N;
		end
	end

	always_comb begin
		case (uw.cond)
			C_NEVER: cond_hit = 1'b0;
			C_ALWAYS: cond_hit = 1'b1;
			C_NO_REQ: cond_hit = !req_fire;
			C_ERR: cond_hit = (err_code != ST_OK);
			C_BUSY: cond_hit = (cnt_q != CW'(1));
			C_NSMALL: cond_hit = (n_round <= N_W'(1));
			C_MORE: cond_hit = !(res_fire && is_last);
			default: cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
			tfps_q <= SRC_W'(512);
			maxf_q <= N_W'(64);
			grp_q <= GRP_W'(2);
		end else begin
			pc_q <= cond_hit ? uw.tgt : pc_q + PC_W'(1);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TARGET_FPS: tfps_q <= cfg_data;
					REG_MAX_FRAMES: maxf_q <= cfg_data[N_W-1:0];
					REG_GROUP_SIZE: grp_q <= cfg_data[GRP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign acc_sum = {1'b0, accr_q} + {1'b0, r0_q};

	always_ff @(posedge clk) begin
		if (req_fire) begin
			total_q <= req.total_frames;
			src_q <= req.source_fps;
		end
		if (uw.chk) begin
			st_q <= err_code;
			n_q <= N_W'(1);
			i_q <= '0;
			acc_q <= '0;
			accr_q <= '0;
		end
		case (uw.div_ld)
			DL_PROD: begin
				dvd_q <= W'(total_q) * W'(tfps_q);
				dsr_q <= src_q;
				rem_q <= '0;
				cnt_q <= CW'(W);
			end
			DL_NG: begin
				dvd_q <= {n_clamp, {(W-N_W){1'b0}}};
				dsr_q <= SRC_W'(g_eff);
				rem_q <= '0;
				cnt_q <= CW'(N_W);
			end
			DL_SPAN: begin
				dvd_q <= {total_q - FCB'(1), {SRC_W{1'b0}}};
				dsr_q <= SRC_W'(n_round - N_W'(1));
				rem_q <= '0;
				cnt_q <= CW'(FCB);
			end
			default: begin
				if (uw.div_run) begin
					dvd_q <= {dvd_q[W-2:0], qbit};
					rem_q <= rem_nx[SRC_W-1:0];
					cnt_q <= cnt_q - CW'(1);
				end
			end
		endcase
		if (uw.clamp) begin
			n_q <= n_clamp;
		end
		if (uw.round) begin
			n_q <= n_round;
		end
		if (uw.step_ld) begin
			q0_q <= dvd_q[FCB-1:0];
			r0_q <= rem_q[N_W-1:0];
		end
		if (uw.emit && res_fire && !is_last) begin
			i_q <= i_q + N_W'(1);
			if (acc_sum >= {1'b0, d_n}) begin
				accr_q <= N_W'(acc_sum - {1'b0, d_n});
				acc_q <= acc_q + q0_q + FCB'(1);
			end else begin
				accr_q <= acc_sum[N_W-1:0];
				acc_q <= acc_q + q0_q;
			end
		end
	end

	assign idx_ext = {{IDX_W{1'b0}}, acc_q};
	assign req.ready = uw.in_rdy;
	assign res.valid = uw.emit;
	assign res.frame_index = idx_ext[IDX_W-1:0];
	assign res.status = st_q;
	assign res.last = is_last;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status != ST_OK) |-> (res.frame_index == '0) && res.last)
		else $error("error result must be a single zero index");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (i_q == '0) |-> (acc_q == '0))
		else $error("first index of a request must be zero");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !res.valid)
		else $error("request accepted while results are pending");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && res.last |=> !res.valid)
		else $error("result shown after the final one");

endmodule
`default_nettype wire
